/* rtl/core/fss_pkg.sv */
package fss_pkg;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLOCK = 2'd2,
    ACT_HOLD  = 2'd3
  } action_t;

  localparam logic [2:0] REG_LOOP_A  = 3'd0;
  localparam logic [2:0] REG_LOOP_B  = 3'd1;
  localparam logic [2:0] REG_LAST    = 3'd2;
  localparam logic [2:0] REG_OFFSET  = 3'd3;
  localparam logic [2:0] REG_MODE    = 3'd4;
  localparam logic [2:0] REG_CLK_SEL = 3'd5;
  localparam logic [2:0] REG_PERIOD  = 3'd6;
  localparam logic [2:0] REG_DELAY   = 3'd7;

  localparam logic [1:0] TR_SCRATCH = 2'd1;
  localparam logic [1:0] TR_NORMAL  = 2'd2;

  localparam logic [2:0] CLK_INTERNAL = 3'd0;
  localparam logic [2:0] CLK_MAX_SEL  = 3'd5;

  localparam logic [9:0] SCRATCH_SPAN = 10'd255;

  typedef struct packed {
    logic [1:0]        action;
    logic              key_held;
    logic signed [7:0] scratch_value;
  } item_t;

  typedef struct packed {
    logic [8:0] step;
    logic       running;
    logic       forward;
    logic       active;
  } result_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic div;
    logic adv;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic to_mul;
    logic to_adv;
    logic adv_last;
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_ADV,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/fss_ctrl.sv */
module fss_ctrl
  import fss_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  input  logic  result_stall,
  input  stat_t stat,
  output logic  item_stall,
  output logic  result_valid,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        priority if (stat.to_mul) state_next = ST_MUL;
        else if (stat.to_adv)     state_next = ST_ADV;
        else                      state_next = ST_DONE;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div    = 1'b1;
        state_next = ST_DONE;
      end
      ST_ADV: begin
        cmd.adv = 1'b1;
        if (stat.adv_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (cmd.load_out) result_valid_next = 1'b1;
    else if (!result_stall) result_valid_next = 1'b0;
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && item_valid) |=> state == ST_EXEC)
    else $error("accepted request not executed");

  a_mul_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |=> state == ST_DIV)
    else $error("scratch multiply not followed by divide");

  a_adv_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADV && !stat.adv_last) |=> state == ST_ADV)
    else $error("advance sequence cut short");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(result_valid && result_stall))
    else $error("stalled result overwritten");

endmodule

/* rtl/core/fss_datapath.sv */
module fss_datapath
  import fss_pkg::*;
#(
  parameter int MAX_LAST_STEP = 511
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  item_t       item_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  output result_t     result_data
);

  localparam logic [13:0] MaxLast = 14'(MAX_LAST_STEP);

  logic [13:0] reg_a, reg_b, reg_off;
  logic [8:0]  reg_last;
  logic [3:0]  reg_mode;
  logic [2:0]  reg_clk;
  logic [23:0] reg_period;
  logic [15:0] reg_delay;

  logic [8:0]  position;
  logic        direction_fwd, run_flag, hold_flag;
  logic [23:0] tick_accumulator;
  logic [1:0]  clock_quarters;
  logic [15:0] delay_left;

  item_t       item;
  logic [16:0] prod;
  logic [2:0]  count;
  result_t     result;

  logic [8:0]  last, pa, pb, lo, hi, off, start_pos;
  logic        seq_valid, go;
  logic [1:0]  transport;
  logic [23:0] per;
  logic [24:0] acc;
  logic        acc_hit, tick_ok, midi_ok;
  logic [2:0]  sel;
  logic [4:0]  total;
  logic [10:0] pos_s, lo_s, hi_s, last_s;
  logic [8:0]  adv_pos;
  logic        adv_fwd, adv_run;
  logic [8:0]  q0;
  logic [9:0]  rem, quot;
  logic [8:0]  scr_pos;

  function automatic logic [8:0] clamp_last(input logic [13:0] v, input logic [8:0] l);
    clamp_last = (v > {5'd0, l}) ? l : v[8:0];
  endfunction

  always_comb begin
    last      = ({5'd0, reg_last} > MaxLast) ? MaxLast[8:0] : reg_last;
    pa        = clamp_last(reg_a, last);
    pb        = clamp_last(reg_b, last);
    lo        = (pa < pb) ? pa : pb;
    hi        = (pa < pb) ? pb : pa;
    off       = clamp_last(reg_off, last);
    start_pos = (reg_b >= reg_a) ? off : last - off;
    seq_valid = reg_mode[3];
    transport = reg_mode[2:1];
    go        = (delay_left == 16'd0) || (delay_left == 16'd1);
    per       = (reg_period == 24'd0) ? 24'd1 : reg_period;
    acc       = {1'b0, tick_accumulator} + 25'd1;
    acc_hit   = acc >= {1'b0, per};
    tick_ok   = run_flag && seq_valid && go;
    midi_ok   = run_flag && (reg_clk != CLK_INTERNAL) && seq_valid &&
                (delay_left == 16'd0) && (transport != TR_SCRATCH);
    sel       = (reg_clk > CLK_MAX_SEL) ? CLK_MAX_SEL : reg_clk;
    total     = {3'd0, clock_quarters} + (5'd1 << (sel - 3'd1));
  end

  always_comb begin
    lo_s    = {2'b00, lo};
    hi_s    = {2'b00, hi};
    last_s  = {2'b00, last};
    pos_s   = direction_fwd ? {2'b00, position} + 11'd1 : {2'b00, position} - 11'd1;
    adv_pos = pos_s[8:0];
    adv_fwd = direction_fwd;
    adv_run = run_flag;
    if (reg_mode[0]) begin
      if ($signed(pos_s) >= $signed(hi_s)) begin
        adv_pos = hi;
        adv_fwd = 1'b0;
      end else if ($signed(pos_s) <= $signed(lo_s)) begin
        adv_pos = lo;
        adv_fwd = 1'b1;
      end
    end else if (hold_flag) begin
      if (direction_fwd && ($signed(pos_s) > $signed(hi_s))) begin
        adv_pos = lo;
        if (lo == hi) adv_run = 1'b0;
      end else if (!direction_fwd && ($signed(pos_s) < $signed(lo_s))) begin
        adv_pos = hi;
        if (lo == hi) adv_run = 1'b0;
      end
    end else begin
      if ($signed(pos_s) >= $signed(last_s)) begin
        adv_pos = last;
        adv_run = 1'b0;
      end else if ($signed(pos_s) <= $signed(11'sd0)) begin
        adv_pos = 9'd0;
        adv_run = 1'b0;
      end
    end
  end

  // x / 255 as x/256 plus a remainder correction of at most two
  always_comb begin
    q0   = prod[16:8];
    rem  = {2'b00, prod[7:0]} + {1'b0, q0};
    quot = {1'b0, q0};
    if (rem >= {SCRATCH_SPAN[8:0], 1'b0}) quot = {1'b0, q0} + 10'd2;
    else if (rem >= SCRATCH_SPAN)        quot = {1'b0, q0} + 10'd1;
    scr_pos = (quot > {1'b0, last}) ? last : quot[8:0];
  end

  always_comb begin
    stat.to_mul   = (item.action == ACT_TICK) && tick_ok && (transport == TR_SCRATCH);
    stat.to_adv   = ((item.action == ACT_TICK) && tick_ok && (transport != TR_SCRATCH) &&
                     (reg_clk == CLK_INTERNAL) && acc_hit) ||
                    ((item.action == ACT_CLOCK) && midi_ok && (total[4:2] != 3'd0));
    stat.adv_last = (count == 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a            <= '0;
      reg_b            <= '0;
      reg_last         <= '0;
      reg_off          <= '0;
      reg_mode         <= '0;
      reg_clk          <= '0;
      reg_period       <= 24'd1;
      reg_delay        <= '0;
      position         <= '0;
      direction_fwd    <= 1'b1;
      run_flag         <= 1'b0;
      hold_flag        <= 1'b0;
      tick_accumulator <= '0;
      clock_quarters   <= '0;
      delay_left       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LOOP_A:  reg_a      <= cfg_data[13:0];
          REG_LOOP_B:  reg_b      <= cfg_data[13:0];
          REG_LAST:    reg_last   <= cfg_data[8:0];
          REG_OFFSET:  reg_off    <= cfg_data[13:0];
          REG_MODE:    reg_mode   <= cfg_data[3:0];
          REG_CLK_SEL: reg_clk    <= cfg_data[2:0];
          REG_PERIOD:  reg_period <= cfg_data;
          REG_DELAY:   reg_delay  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        unique case (item.action)
          ACT_START: begin
            direction_fwd    <= (reg_b >= reg_a);
            position         <= start_pos;
            tick_accumulator <= '0;
            clock_quarters   <= '0;
            run_flag         <= 1'b1;
            hold_flag        <= 1'b1;
            delay_left       <= reg_delay;
          end
          ACT_TICK: begin
            if (run_flag && seq_valid) begin
              if (delay_left != 16'd0) delay_left <= delay_left - 16'd1;
              if (go && (transport != TR_SCRATCH) && (reg_clk == CLK_INTERNAL)) begin
                if (acc_hit) begin
                  tick_accumulator <= 24'(acc - {1'b0, per});
                  count            <= 3'd1;
                end else begin
                  tick_accumulator <= acc[23:0];
                end
              end
            end
          end
          ACT_CLOCK: begin
            if (midi_ok) begin
              clock_quarters <= total[1:0];
              count          <= total[4:2];
            end
          end
          ACT_HOLD: hold_flag <= item.key_held;
          default: ;
        endcase
      end
      if (cmd.div) position <= scr_pos;
      if (cmd.adv) begin
        position      <= adv_pos;
        direction_fwd <= adv_fwd;
        run_flag      <= adv_run;
        count         <= count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item <= item_data;
    if (cmd.mul) prod <= {9'd0, ~item.scratch_value[7], item.scratch_value[6:0]} * {8'd0, last};
    if (cmd.load_out) begin
      result.step    <= position;
      result.running <= run_flag;
      result.forward <= direction_fwd;
      result.active  <= seq_valid && ((transport == TR_SCRATCH) || (transport == TR_NORMAL)) &&
                        (delay_left == 16'd0);
    end
  end

  assign result_data = result;

  a_adv_count: assert property (@(posedge clk) disable iff (rst)
    cmd.adv |-> (count != 3'd0) && (count <= 3'd4))
    else $error("advance count out of range");

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && item.action == ACT_START) |=> run_flag && hold_flag)
    else $error("start did not arm run and hold");

  a_scratch_range: assert property (@(posedge clk) disable iff (rst)
    cmd.div |=> position <= $past(last))
    else $error("scratch position beyond last step");

endmodule

/* rtl/core/formant_sequence_stepper.sv */
// Channel   Handshake                Payload
// item      item_valid / item_stall  item_data (item_t)
// result    result_valid / result_stall  result_data (result_t)
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One request per item, taken only when the sequencer is idle; a result
// waiting in the output register does not hold off the next request.
// Each item passes through the idle, execute and done states; a timer
// step adds an advance state, a scratch update a multiply then a divide
// state, and a MIDI clock advances n (up to 4) steps, one per cycle.
// rst is synchronous; cfg_ready is always high.
module formant_sequence_stepper
  import fss_pkg::*;
#(
  parameter int MAX_LAST_STEP = 511
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item_data,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  fss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  fss_datapath #(
    .MAX_LAST_STEP (MAX_LAST_STEP)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_data   (item_data),
    .cmd         (cmd),
    .stat        (stat),
    .result_data (result_data)
  );

endmodule
